/* rtl/core/aip_pkg.sv */
package aip_pkg;

  // longest string tracked; positions saturate here
  localparam int MaxLen  = 4096;
  localparam int PosW    = 13;
  localparam int AccW    = 64;
  localparam int BaseW   = 6;
  localparam int ProdW   = AccW + BaseW;
  localparam int OutW    = 80;

  // parse phases
  localparam logic [2:0] PH_SPACE   = 3'd0;
  localparam logic [2:0] PH_SIGNED  = 3'd1;
  localparam logic [2:0] PH_ZERO    = 3'd2;
  localparam logic [2:0] PH_PREFIX  = 3'd3;
  localparam logic [2:0] PH_DIGITS  = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_BADBASE = 3'd6;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BASE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_NUMBER_BASE   = 2'd0;
  localparam logic [1:0] CFG_SIGNED_RESULT = 2'd1;
  localparam logic [1:0] CFG_NARROW_RANGE  = 2'd2;

  localparam logic [PosW-1:0] POS_MAX = PosW'(MaxLen);

  typedef struct packed {
    logic [2:0]       phase;
    logic [AccW-1:0]  acc;
    logic             ov;
    logic             neg;
    logic [BaseW-1:0] base;
    logic             digits;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  endp;
  } parse_t;

  function automatic logic [BaseW-1:0] digit_value(input logic [7:0] c);
    logic [BaseW-1:0] d;
    d = 6'd36;
    if (c >= "0" && c <= "9") d = BaseW'(c - 8'h30);
    else if (c >= "A" && c <= "Z") d = BaseW'(c - 8'h41 + 8'd10);
    else if (c >= "a" && c <= "z") d = BaseW'(c - 8'h61 + 8'd10);
    return d;
  endfunction

  function automatic logic base_invalid(input logic [BaseW-1:0] b);
    return (b == 6'd1) || (b > 6'd36);
  endfunction

  function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] p);
    return (p >= POS_MAX) ? POS_MAX : p + 1'b1;
  endfunction

endpackage

/* rtl/core/aip_step.sv */
module aip_step (
  input  aip_pkg::parse_t       cur,
  input  logic [7:0]            char_code,
  input  logic [5:0]            number_base,
  output aip_pkg::parse_t       nxt
);
  import aip_pkg::*;

  logic [BaseW-1:0] d;
  logic [BaseW-1:0] begin_base;
  logic [BaseW-1:0] tb;
  logic [ProdW-1:0] prod;
  logic             starting;
  logic             is_space;
  logic             zero_lead;

  assign d          = digit_value(char_code);
  assign starting   = (cur.phase == PH_SPACE) || (cur.phase == PH_SIGNED);
  assign is_space   = (char_code == " ") || (char_code >= 8'd9 && char_code <= 8'd13);
  assign zero_lead  = ((number_base == 6'd0) || (number_base == 6'd16)) && (char_code == "0");
  assign begin_base = (number_base == 6'd0) ? 6'd10 : number_base;
  // one multiply-add shared by the first-digit and later-digit paths; a leading zero loads zero directly
  assign tb         = starting ? begin_base : cur.base;
  assign prod       = ProdW'(cur.acc) * ProdW'(tb) + ProdW'(d);

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_SPACE, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS: begin
        if (cur.phase == PH_SPACE && is_space) begin
          nxt.phase = PH_SPACE;
        end else if (cur.phase == PH_SPACE && (char_code == "-" || char_code == "+")) begin
          nxt.neg   = (char_code == "-");
          nxt.phase = PH_SIGNED;
        end else if (starting && zero_lead) begin
          nxt.acc    = '0;
          nxt.digits = 1'b1;
          nxt.endp   = next_pos(cur.pos);
          nxt.base   = (number_base == 6'd16) ? 6'd16 : 6'd8;
          nxt.phase  = PH_ZERO;
        end else if (starting && base_invalid(begin_base)) begin
          nxt.phase = PH_BADBASE;
        end else if (cur.phase == PH_ZERO && (char_code == "x" || char_code == "X")) begin
          nxt.base  = 6'd16;
          nxt.phase = PH_PREFIX;
        end else begin
          if (starting) nxt.base = begin_base;
          if (tb < 6'd2 || d >= tb) begin
            nxt.phase = PH_DONE;
          end else begin
            if (cur.ov || (prod[ProdW-1:AccW] != '0)) begin
              nxt.ov  = 1'b1;
              nxt.acc = '1;
            end else begin
              nxt.acc = prod[AccW-1:0];
            end
            nxt.digits = 1'b1;
            nxt.endp   = next_pos(cur.pos);
            nxt.phase  = PH_DIGITS;
          end
        end
      end
      default: begin
        nxt.phase = cur.phase;
      end
    endcase
    nxt.pos = next_pos(cur.pos);
  end

endmodule

/* rtl/core/aip_clamp.sv */
module aip_clamp (
  input  aip_pkg::parse_t  fin,
  input  logic [5:0]       number_base,
  input  logic             signed_result,
  input  logic             narrow_range,
  output logic [63:0]      value,
  output logic [1:0]       status,
  output logic [12:0]      end_offset
);
  import aip_pkg::*;

  logic [AccW-1:0] lim;
  logic [AccW-1:0] v;
  logic            ov;

  assign lim = narrow_range ? (64'd1 << 31) : (64'd1 << 63);

  always_comb begin
    v          = fin.acc;
    ov         = fin.ov;
    value      = '0;
    status     = ST_OK;
    end_offset = '0;
    if (fin.phase == PH_BADBASE ||
        ((fin.phase == PH_SPACE || fin.phase == PH_SIGNED) && base_invalid(number_base))) begin
      status = ST_BASE;
    end else if (fin.digits) begin
      if (fin.neg) begin
        if (v > lim) ov = 1'b1;
        if (ov) v = lim;
        v = 64'd0 - v;
      end else if (signed_result) begin
        if (v >= lim) ov = 1'b1;
        if (ov) v = lim - 64'd1;
      end else if (narrow_range) begin
        if (v[63:32] != '0) ov = 1'b1;
        if (ov) v = 64'h0000_0000_FFFF_FFFF;
      end else begin
        if (ov) v = '1;
      end
      value      = v;
      status     = ov ? ST_RANGE : ST_OK;
      end_offset = fin.endp;
    end
  end

endmodule

/* rtl/core/ascii_integer_parser.sv */
// channel | dir | beat contents                                  | handshake
// s_*     | in  | tdata[7:0] char_code, tlast last_char           | tvalid/tready
// m_*     | out | tdata value, status, end_offset (80 bits)       | tvalid/tready
// cfg_*   | in  | cfg_index register, cfg_data value             | cfg_valid/cfg_ready
//
// one byte per cycle sustained while no last byte waits on the snapshot slot;
// the last byte lands in the input register when accepted and its result then
// passes the snapshot register and the output register
// the 64x6 multiply-add of the digit step sets the critical path
// rst is synchronous and clears parse state, config to defaults, all valids
// a stalled output holds the snapshot; only the last byte of a string waits
// on it, other bytes keep flowing until that byte blocks the input register
module ascii_integer_parser (
  input  logic        clk,
  input  logic        rst,
  // slave stream: one string byte per beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  // master stream: one result per string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [63:0] value, [65:64] status, [78:66] end_offset, [79] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import aip_pkg::*;

  // configuration registers
  logic [5:0] number_base;
  logic       signed_result;
  logic       narrow_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base   <= 6'd10;
      signed_result <= 1'b1;
      narrow_range  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUMBER_BASE:   number_base   <= cfg_data[5:0];
        CFG_SIGNED_RESULT: signed_result <= cfg_data[0];
        CFG_NARROW_RANGE:  narrow_range  <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // snapshot of the finished parse, waiting for the output register
  logic   snap_valid;
  parse_t snap;

  parse_t par;
  parse_t par_next;

  logic out_free;
  logic snap_free;
  logic in_go;

  assign out_free  = !m_tvalid || m_tready;
  assign snap_free = !snap_valid || out_free;
  // a last byte may only move on once the snapshot slot is free
  assign in_go     = in_valid && (!in_last || snap_free);
  assign s_tready  = !in_valid || in_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  aip_step u_step (
    .cur         (par),
    .char_code   (in_char),
    .number_base (number_base),
    .nxt         (par_next)
  );

  // parse state; a string end returns it to the start
  always_ff @(posedge clk) begin
    if (rst) begin
      par <= '{phase: PH_SPACE, default: '0};
    end else if (in_go) begin
      if (in_last) par <= '{phase: PH_SPACE, default: '0};
      else         par <= par_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_go && in_last) begin
      snap_valid <= 1'b1;
    end else if (out_free) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_last) snap <= par_next;
  end

  // clamp and status from the snapshot
  logic [63:0] res_value;
  logic [1:0]  res_status;
  logic [12:0] res_end;

  aip_clamp u_clamp (
    .fin           (snap),
    .number_base   (number_base),
    .signed_result (signed_result),
    .narrow_range  (narrow_range),
    .value         (res_value),
    .status        (res_status),
    .end_offset    (res_end)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      m_tdata <= {1'b0, res_end, res_status, res_value};
    end
  end

  // a finished string leaves the parser at its start
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_go && in_last |=> par.phase == PH_SPACE && par.pos == '0 && !par.digits)
    else $error("parse state not cleared after last byte");

  // sticky overflow pins the accumulator at all ones
  a_ov_sat: assert property (@(posedge clk) disable iff (rst)
    par.ov |-> par.acc == '1)
    else $error("overflow without saturated accumulator");

  // the digit end never runs ahead of the byte count
  a_end_pos: assert property (@(posedge clk) disable iff (rst)
    par.endp <= par.pos)
    else $error("end position beyond byte position");

  // a pending snapshot is never overwritten before it moves out
  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !out_free |=> snap_valid && $stable(snap))
    else $error("snapshot lost while output stalled");

endmodule
